FILE: sv/cbps_pkg.sv
// Shared types, constants and step tables of the path smoother.
package cbps_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CNT_W           = 5;
  localparam int T_W             = 17;
  localparam int W_W             = 49;
  localparam int N_MAX           = 21;
  localparam int N_RESET         = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG,
    ST_WGT,
    ST_ACC,
    ST_DRAIN,
    ST_FIN,
    ST_EMIT,
    ST_PASS,
    ST_DONE
  } state_t;

  // Segment kinds: which window slots act as prev, start, end and next.
  typedef enum logic [1:0] {
    K_A,
    K_B,
    K_C
  } kind_t;

  typedef struct packed {
    logic       acc_en;
    logic       acc_clr;
    logic [1:0] shift_sel;
  } mac_ctl_t;

  // Integer part of 65536 / n.
  function automatic logic [T_W-1:0] qstep(input logic [CNT_W-1:0] n);
    logic [T_W-1:0] q;
    unique case (n)
      5'd1:    q = 17'd65536;
      5'd2:    q = 17'd32768;
      5'd3:    q = 17'd21845;
      5'd4:    q = 17'd16384;
      5'd5:    q = 17'd13107;
      5'd6:    q = 17'd10922;
      5'd7:    q = 17'd9362;
      5'd8:    q = 17'd8192;
      5'd9:    q = 17'd7281;
      5'd10:   q = 17'd6553;
      5'd11:   q = 17'd5957;
      5'd12:   q = 17'd5461;
      5'd13:   q = 17'd5041;
      5'd14:   q = 17'd4681;
      5'd15:   q = 17'd4369;
      5'd16:   q = 17'd4096;
      5'd17:   q = 17'd3855;
      5'd18:   q = 17'd3640;
      5'd19:   q = 17'd3449;
      5'd20:   q = 17'd3276;
      5'd21:   q = 17'd3120;
      default: q = 17'd0;
    endcase
    return q;
  endfunction

  // Remainder of 65536 / n.
  function automatic logic [CNT_W-1:0] rstep(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    unique case (n)
      5'd3, 5'd5, 5'd15, 5'd17:   r = 5'd1;
      5'd7, 5'd14:                r = 5'd2;
      5'd13:                      r = 5'd3;
      5'd6, 5'd12:                r = 5'd4;
      5'd19:                      r = 5'd5;
      5'd10:                      r = 5'd6;
      5'd9:                       r = 5'd7;
      5'd11:                      r = 5'd9;
      5'd18, 5'd20, 5'd21:        r = 5'd16;
      default:                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/cbps_mac.sv
// Shared multiplier with product register, shifting accumulator and rounding.
module cbps_mac #(
  parameter int COORD_WIDTH = cbps_pkg::COORD_WIDTH_DEF,
  parameter int MA_W        = 35
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [MA_W-1:0]         op_a,
  input  logic [cbps_pkg::T_W-1:0]       op_b,
  input  cbps_pkg::mac_ctl_t             ctl,
  output logic signed [MA_W+17:0]        prod,
  output logic [COORD_WIDTH-1:0]         res
);
  import cbps_pkg::*;

  localparam int P_W  = MA_W + 18;
  localparam int AW   = COORD_WIDTH + 51;
  localparam int TW   = P_W + 34;
  localparam int RW   = AW - 48;
  localparam logic [AW-1:0] HALF = {{(AW-48){1'b0}}, 1'b1, 47'b0};

  logic signed [P_W-1:0] prod_r;
  logic signed [P_W-1:0] prod_nxt;
  mac_ctl_t              ctl_r;
  logic [AW-1:0]         acc_r;
  logic [AW-1:0]         acc_nxt;
  logic [TW-1:0]         ext;
  logic [TW-1:0]         term;
  logic [AW-1:0]         rnd;
  logic [RW-1:0]         qv;
  logic                  ovf;

  assign prod_nxt = op_a * $signed({1'b0, op_b});
  assign ext      = {{34{prod_r[P_W-1]}}, prod_r};

  always_comb begin
    case (ctl_r.shift_sel)
      2'd0:    term = ext;
      2'd1:    term = ext << 17;
      default: term = ext << 34;
    endcase
    acc_nxt = ctl_r.acc_clr ? term[AW-1:0] : acc_r + term[AW-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    if (ctl_r.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Round half up, then clamp to the coordinate range.
  always_comb begin
    rnd = acc_r + HALF;
    qv  = rnd[AW-1:48];
    ovf = (qv[RW-1:COORD_WIDTH-1] != {(RW-COORD_WIDTH+1){1'b0}}) &&
          (qv[RW-1:COORD_WIDTH-1] != {(RW-COORD_WIDTH+1){1'b1}});
    if (ovf) begin
      res = qv[RW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      res = qv[COORD_WIDTH-1:0];
    end
  end

  assign prod = prod_r;

endmodule

FILE: sv/cbps_out_reg.sv
// One-entry output register between the sequencer and the result stream.
module cbps_out_reg #(
  parameter int COORD_WIDTH = cbps_pkg::COORD_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      ld_en,
  input  logic [COORD_WIDTH-1:0]                    ld_x,
  input  logic [COORD_WIDTH-1:0]                    ld_y,
  input  logic                                      ld_fin,
  output logic                                      ld_rdy,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        out_tdata,
  output logic                                      out_tlast
);
  import cbps_pkg::*;

  localparam int DATA_W = ((2*COORD_WIDTH+7)/8)*8;

  logic                   valid_r;
  logic [DATA_W-1:0]      data_r;
  logic                   last_r;

  assign ld_rdy = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_rdy) begin
      valid_r <= ld_en;
    end
    if (ld_en && ld_rdy) begin
      data_r <= DATA_W'({ld_y, ld_x});
      last_r <= ld_fin;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

FILE: sv/catmull_bezier_path_smoother_core.sv
// Top level of the Catmull-Rom path smoother with its sequencer and waypoint window.
// Waypoints come in one transfer at a time on the in_ stream (tlast marks the last waypoint
// of a path) and the smoothed path leaves on the out_ stream, tlast set on its closing point.
// Every curve sample is built by one shared multiplier under a small sequencer: it forms the
// Bernstein weights for t = s/N, then per axis multiplies four control coefficients by three
// weight slices of 17, 17 and 15 bits into the accumulator, then drains and rounds; the sample
// is emitted once the output register can take it. Each waypoint from the fourth on releases
// one segment of N samples (the fourth one also the opening segment), N being the configured
// sample count per segment clamped to 1..21; the final waypoint of a path adds a closing
// segment and its own closing transfer. in_tready is high only while the block is idle. Paths
// of fewer than four waypoints come out unchanged. Coordinates are signed with 16 fraction bits,
// rounded half up and clamped. The sample count is written through cfg_we/cfg_wdata and resets
// to 8; it should be changed only between items.
module catmull_bezier_path_smoother_core #(
  parameter int COORD_WIDTH = cbps_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // point_x, point_y, zero fill
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  // end_of_path
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // sample_x, sample_y, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  // final_sample
  output logic                                  out_tlast,
  input  logic                                  cfg_we,
  input  logic [cbps_pkg::CNT_W-1:0]            cfg_wdata
);
  import cbps_pkg::*;

  localparam int C_W  = COORD_WIDTH + 3;
  localparam int MA_W = (COORD_WIDTH + 3 > 34) ? COORD_WIDTH + 3 : 34;
  localparam int P_W  = MA_W + 18;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cfg_n_r;
  logic [COORD_WIDTH-1:0]       win_x_r [3];
  logic [COORD_WIDTH-1:0]       win_y_r [3];
  logic [COORD_WIDTH-1:0]       cur_x_r, cur_y_r;
  logic                         last_r;
  logic [2:0]                   seen_r;
  kind_t                        kind_r, kind_end_r;
  logic [1:0]                   pi_r;
  logic [2:0]                   step_r;
  logic [1:0]                   ci_r, ch_r;
  logic                         axis_r;
  logic [CNT_W-1:0]             n_r, s_r, r_r;
  logic [T_W-1:0]               q_r;
  logic [32:0]                  uu_r, tt_r;
  logic [W_W-1:0]               w_r [4];
  logic signed [C_W-1:0]        coef_r [2][4];
  logic [COORD_WIDTH-1:0]       sx_r;

  logic [COORD_WIDTH-1:0]       pt [2][4];
  logic signed [C_W-1:0]        coef_nxt [2][4];
  logic [CNT_W-1:0]             n_eff;
  logic [CNT_W:0]               r_sum;
  logic                         wrap;
  logic [CNT_W-1:0]             r_nxt;
  logic [T_W-1:0]               q_nxt;
  logic [T_W-1:0]               t_val, u_val;
  logic                         seg_end;
  logic                         ld_en, ld_rdy, ld_fin;
  logic [COORD_WIDTH-1:0]       ld_x, ld_y;
  logic signed [MA_W-1:0]       op_a;
  logic [T_W-1:0]               op_b;
  mac_ctl_t                     mac_ctl;
  logic signed [P_W-1:0]        prod;
  logic [COORD_WIDTH-1:0]       mac_res;
  logic [W_W-1:0]               w_sel;

  // Slots 0..2 hold the window, oldest first; slot 3 is the current waypoint.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[0][i] = win_x_r[i];
      pt[1][i] = win_y_r[i];
    end
    pt[0][3] = cur_x_r;
    pt[1][3] = cur_y_r;
  end

  // Control coefficients of a segment: start, the two inner Bezier terms, end.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      logic signed [C_W-1:0] ep, ea, eb, en;
      unique case (kind_r)
        K_A: begin
          ep = C_W'($signed(pt[a][0])); ea = C_W'($signed(pt[a][0]));
          eb = C_W'($signed(pt[a][1])); en = C_W'($signed(pt[a][2]));
        end
        K_B: begin
          ep = C_W'($signed(pt[a][0])); ea = C_W'($signed(pt[a][1]));
          eb = C_W'($signed(pt[a][2])); en = C_W'($signed(pt[a][3]));
        end
        default: begin
          ep = C_W'($signed(pt[a][1])); ea = C_W'($signed(pt[a][2]));
          eb = C_W'($signed(pt[a][3])); en = C_W'($signed(pt[a][3]));
        end
      endcase
      coef_nxt[a][0] = ea;
      coef_nxt[a][1] = (ea <<< 1) + ea + eb - ep;
      coef_nxt[a][2] = (eb <<< 1) + eb - en + ea;
      coef_nxt[a][3] = eb;
    end
  end

  always_comb begin
    if (cfg_n_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_n_r > CNT_W'(N_MAX)) begin
      n_eff = CNT_W'(N_MAX);
    end else begin
      n_eff = cfg_n_r;
    end
  end

  // t advances by 65536/N per sample; the remainder carries the rounding exactly.
  assign r_sum   = {1'b0, r_r} + {1'b0, rstep(n_r)};
  assign wrap    = r_sum >= {1'b0, n_r};
  assign r_nxt   = wrap ? CNT_W'(r_sum - {1'b0, n_r}) : r_sum[CNT_W-1:0];
  assign q_nxt   = q_r + qstep(n_r) + T_W'(wrap);
  assign t_val   = q_r;
  assign u_val   = 17'h10000 - q_r;
  assign seg_end = (s_r == n_r - CNT_W'(1));

  // Shared multiplier operands: weight products first, then coefficient times weight slice.
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    mac_ctl = '0;
    w_sel   = w_r[ci_r];
    if (state_r == ST_WGT) begin
      case (step_r)
        3'd0: begin op_a = MA_W'(u_val);  op_b = u_val; end
        3'd1: begin op_a = MA_W'(t_val);  op_b = t_val; end
        3'd2: begin op_a = MA_W'(uu_r);   op_b = u_val; end
        3'd3: begin op_a = MA_W'(uu_r);   op_b = t_val; end
        3'd4: begin op_a = MA_W'(tt_r);   op_b = u_val; end
        3'd5: begin op_a = MA_W'(tt_r);   op_b = t_val; end
        default: begin op_a = '0;         op_b = '0;    end
      endcase
    end else if (state_r == ST_ACC) begin
      op_a = MA_W'(coef_r[axis_r][ci_r]);
      case (ch_r)
        2'd0:    op_b = w_sel[16:0];
        2'd1:    op_b = w_sel[33:17];
        default: op_b = {2'b00, w_sel[48:34]};
      endcase
      mac_ctl.acc_en    = 1'b1;
      mac_ctl.acc_clr   = (ci_r == 2'd0) && (ch_r == 2'd0);
      mac_ctl.shift_sel = ch_r;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (seen_r >= 3'd3) begin
            state_nxt = ST_SEG;
          end else if (in_tlast) begin
            state_nxt = ST_PASS;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SEG:   state_nxt = ST_WGT;
      ST_WGT: begin
        if (step_r == 3'd6) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (ci_r == 2'd3 && ch_r == 2'd2) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        state_nxt = axis_r ? ST_EMIT : ST_ACC;
      end
      ST_EMIT: begin
        if (ld_rdy) begin
          if (!seg_end) begin
            state_nxt = ST_WGT;
          end else if (kind_r != kind_end_r) begin
            state_nxt = ST_SEG;
          end else if (last_r) begin
            state_nxt = ST_PASS;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PASS: begin
        if (ld_rdy && pi_r == 2'd3) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cfg_n_r    <= CNT_W'(N_RESET);
      seen_r     <= '0;
      last_r     <= 1'b0;
      kind_r     <= K_A;
      kind_end_r <= K_A;
      pi_r       <= '0;
      step_r     <= '0;
      ci_r       <= '0;
      ch_r       <= '0;
      axis_r     <= 1'b0;
      n_r        <= CNT_W'(1);
      s_r        <= '0;
      r_r        <= '0;
      q_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_n_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            last_r     <= in_tlast;
            kind_r     <= (seen_r == 3'd3) ? K_A : K_B;
            kind_end_r <= in_tlast ? K_C : K_B;
            pi_r       <= 2'(3'd3 - seen_r);
          end
        end
        ST_SEG: begin
          n_r    <= n_eff;
          s_r    <= '0;
          q_r    <= '0;
          r_r    <= n_eff >> 1;
          step_r <= '0;
        end
        ST_WGT: begin
          step_r <= step_r + 3'd1;
          ci_r   <= '0;
          ch_r   <= '0;
          axis_r <= 1'b0;
        end
        ST_ACC: begin
          if (ch_r == 2'd2) begin
            ch_r <= '0;
            ci_r <= ci_r + 2'd1;
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_FIN: begin
          axis_r <= 1'b1;
          ci_r   <= '0;
          ch_r   <= '0;
        end
        ST_EMIT: begin
          if (ld_rdy) begin
            s_r    <= s_r + CNT_W'(1);
            q_r    <= q_nxt;
            r_r    <= r_nxt;
            step_r <= '0;
            if (seg_end && kind_r != kind_end_r) begin
              kind_r <= kind_t'(kind_r + 2'd1);
            end
            if (seg_end && kind_r == kind_end_r) begin
              pi_r <= 2'd3;
            end
          end
        end
        ST_PASS: begin
          if (ld_rdy) begin
            pi_r <= pi_r + 2'd1;
          end
        end
        ST_DONE: begin
          win_x_r[0] <= win_x_r[1];
          win_x_r[1] <= win_x_r[2];
          win_x_r[2] <= cur_x_r;
          win_y_r[0] <= win_y_r[1];
          win_y_r[1] <= win_y_r[2];
          win_y_r[2] <= cur_y_r;
          if (last_r) begin
            seen_r <= '0;
          end else if (seen_r < 3'd4) begin
            seen_r <= seen_r + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cur_x_r <= in_tdata[COORD_WIDTH-1:0];
      cur_y_r <= in_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    end
    if (state_r == ST_SEG) begin
      coef_r <= coef_nxt;
    end
    if (state_r == ST_WGT) begin
      case (step_r)
        3'd1:    uu_r   <= prod[32:0];
        3'd2:    tt_r   <= prod[32:0];
        3'd3:    w_r[0] <= prod[W_W-1:0];
        3'd4:    w_r[1] <= prod[W_W-1:0];
        3'd5:    w_r[2] <= prod[W_W-1:0];
        3'd6:    w_r[3] <= prod[W_W-1:0];
        default: begin
        end
      endcase
    end
    if (state_r == ST_FIN && !axis_r) begin
      sx_r <= mac_res;
    end
  end

  // The y result is read straight from the accumulator while it is held.
  assign ld_en  = ((state_r == ST_EMIT) || (state_r == ST_PASS)) && ld_rdy;
  assign ld_x   = (state_r == ST_PASS) ? pt[0][pi_r] : sx_r;
  assign ld_y   = (state_r == ST_PASS) ? pt[1][pi_r] : mac_res;
  assign ld_fin = (state_r == ST_PASS) && (pi_r == 2'd3);

  cbps_mac #(
    .COORD_WIDTH (COORD_WIDTH),
    .MA_W        (MA_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op_a  (op_a),
    .op_b  (op_b),
    .ctl   (mac_ctl),
    .prod  (prod),
    .res   (mac_res)
  );

  cbps_out_reg #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_en      (ld_en),
    .ld_x       (ld_x),
    .ld_y       (ld_y),
    .ld_fin     (ld_fin),
    .ld_rdy     (ld_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // An accepted waypoint keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // The sample index stays inside the segment.
  a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (s_r < n_r))
    else $error("sample index past segment length");

  // The curve parameter stays below one while weights are formed.
  a_t_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WGT) |-> !q_r[T_W-1])
    else $error("curve parameter reached one");

  // The rounding remainder of t stays below N.
  a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WGT) |-> (r_r < n_r))
    else $error("t remainder out of range");

endmodule
